// File: rtl/core/icod_pkg.sv
// ============================================================================
// icod_pkg
// shared constants, types and helpers of the icon bitmap pixel decoder
// ============================================================================
package icod_pkg;

    localparam int PAYLOAD_BYTES = 32768;
    localparam int PAY_AW        = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 2);
    localparam int MAX_DIM       = 256;
    localparam int MAX_PIXELS    = 65536;
    localparam int DIM_W         = 9;
    localparam int ADDR_W        = 20;
    localparam int HDR_BYTES     = 36;
    localparam int HDR_W         = 8 * HDR_BYTES;
    localparam int HIDX_W        = 6;
    localparam int XS_W          = 13;
    localparam int AS_W          = 7;
    localparam int OFF_W         = 11;
    localparam int BMP_HDR_SIZE  = 40;
    localparam int PNG_MIN       = 24;
    localparam int PAL_MAX       = 256;

    localparam logic [63:0] PNG_SIG = 64'h0A1A_0A0D_474E_5089;

    localparam logic [5:0] DEPTH_1  = 6'd1;
    localparam logic [5:0] DEPTH_4  = 6'd4;
    localparam logic [5:0] DEPTH_8  = 6'd8;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    localparam logic [3:0] ST_OK    = 4'd0;
    localparam logic [3:0] ST_SHORT = 4'd1;
    localparam logic [3:0] ST_BIG   = 4'd2;
    localparam logic [3:0] ST_PNG   = 4'd3;
    localparam logic [3:0] ST_HDR   = 4'd4;
    localparam logic [3:0] ST_DIMS  = 4'd5;
    localparam logic [3:0] ST_DEPTH = 4'd6;
    localparam logic [3:0] ST_PAL   = 4'd7;
    localparam logic [3:0] ST_TRUNC = 4'd8;
    localparam logic [3:0] ST_INDEX = 4'd9;
    localparam logic [3:0] ST_EMPTY = 4'd10;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK_START, S_HDR, S_HDR_LAST, S_EVAL1, S_EVAL2, S_EVAL3,
        S_SCAN_RD, S_SCAN_CHK, S_CHK_RES, S_F_ADDR, S_F_MASK, S_F_PIX,
        S_F_WAIT, S_F_PB, S_F_PG, S_F_PR, S_F_PA, S_F_CAPA, S_F_RES, S_FIN
    } st_t;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_HDR, CAP_MASK, CAP_PIX, CAP_B, CAP_G, CAP_R, CAP_A
    } cap_t;

    typedef enum logic [1:0] {
        RES_CHK, RES_PIX, RES_EMPTY
    } res_t;

    typedef struct packed {
        st_t  op;
        logic load;
        logic miss;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic code_nz;
        logic hdr_last;
        logic pal_mode;
        logic scan_en;
        logic scan_last;
        logic fetch_ok;
        logic out_busy;
    } sts_t;

    function automatic logic [7:0] pal_index(input logic [7:0] pix, input logic [2:0] x,
                                             input logic [5:0] bits);
        logic [7:0] idx;
        case (bits)
            DEPTH_8:
            begin
                idx = pix;
            end
            DEPTH_4:
            begin
                idx = x[0] ? {4'b0, pix[3:0]} : {4'b0, pix[7:4]};
            end
            default:
            begin
                idx = {7'b0, pix[3'd7 - x]};
            end
        endcase
        return idx;
    endfunction

endpackage

// File: rtl/core/icod_ram.sv
// ============================================================================
// icod_ram
// generic single write port ram with registered read
// ============================================================================
module icod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/icod_ctrl.sv
// ============================================================================
// icod_ctrl
// sequencer for load, header check, image scan and pixel fetch
// ============================================================================
module icod_ctrl import icod_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic func,
    input  logic last_byte,
    input  sts_t sts,
    output logic in_stall,
    output cmd_t cmd
);

    st_t  state_reg;
    st_t  state_next;
    logic acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign acc      = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = state_reg;
        cmd.load     = acc && !func;
        cmd.miss     = acc && func && !sts.fetch_ok;
        cmd.out_load = (state_reg == S_FIN) && !sts.out_busy;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!func)
                    begin
                        state_next = last_byte ? S_CHK_START : S_IDLE;
                    end
                    else
                    begin
                        state_next = sts.fetch_ok ? S_F_ADDR : S_FIN;
                    end
                end
            end
            S_CHK_START: state_next = sts.code_nz ? S_CHK_RES : S_HDR;
            S_HDR:       state_next = sts.hdr_last ? S_HDR_LAST : S_HDR;
            S_HDR_LAST:  state_next = S_EVAL1;
            S_EVAL1:     state_next = sts.code_nz ? S_CHK_RES : S_EVAL2;
            S_EVAL2:     state_next = S_EVAL3;
            S_EVAL3:
            begin
                state_next = (!sts.code_nz && sts.scan_en) ? S_SCAN_RD : S_CHK_RES;
            end
            S_SCAN_RD:   state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                state_next = (sts.code_nz || sts.scan_last) ? S_CHK_RES : S_SCAN_RD;
            end
            S_CHK_RES:   state_next = S_FIN;
            S_F_ADDR:    state_next = S_F_MASK;
            S_F_MASK:    state_next = sts.pal_mode ? S_F_PIX : S_F_PB;
            S_F_PIX:     state_next = S_F_WAIT;
            S_F_WAIT:    state_next = S_F_PB;
            S_F_PB:      state_next = S_F_PG;
            S_F_PG:      state_next = S_F_PR;
            S_F_PR:      state_next = S_F_PA;
            S_F_PA:      state_next = S_F_CAPA;
            S_F_CAPA:    state_next = S_F_RES;
            S_F_RES:     state_next = S_FIN;
            S_FIN:       state_next = sts.out_busy ? S_FIN : S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/icod_dp.sv
// ============================================================================
// icod_dp
// payload store, header fields, address arithmetic and result register
// ============================================================================
module icod_dp import icod_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [7:0]       data_byte,
    input  logic             out_stall,
    output sts_t             sts,
    output logic             out_valid,
    output logic             kind,
    output logic [3:0]       status,
    output logic [DIM_W-1:0] image_width,
    output logic [DIM_W-1:0] image_height,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_pixel
);

    // control and image state
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [5:0]        bits_reg;
    logic [8:0]        pal_reg;
    logic              alpha_seen_reg;
    logic              ready_reg;
    logic [DIM_W-1:0]  col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [HIDX_W-1:0] hidx_reg;
    cap_t              cap_reg;
    logic              out_valid_reg;

    // payload registers
    logic [HDR_W-1:0]  hdr_reg;
    logic [3:0]        code_reg;
    logic [XS_W-1:0]   xs_reg;
    logic [AS_W-1:0]   as_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [ADDR_W-1:0] abase_reg;
    logic [DIM_W-1:0]  scan_x_reg;
    logic [DIM_W-1:0]  scan_y_reg;
    logic [ADDR_W-1:0] scan_row_reg;
    logic [ADDR_W-1:0] xrow_reg;
    logic [ADDR_W-1:0] arow_reg;
    logic              mask_reg;
    logic [7:0]        pix_reg;
    logic [7:0]        r_reg;
    logic [7:0]        g_reg;
    logic [7:0]        b_reg;
    logic [7:0]        a_reg;
    logic              last_reg;
    res_t              sel_reg;
    logic              kind_reg;
    logic [3:0]        status_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic [7:0]        alpha_reg;
    logic              lastpix_reg;

    logic [7:0]          rdata;
    logic                we;
    logic [ADDR_W-1:0]   raddr_w;
    cap_t                cap_next;
    logic [3:0]          code_comb;

    // header fields
    logic [31:0]         h_size;
    logic [31:0]         h_w;
    logic [31:0]         h_dh;
    logic [15:0]         h_planes;
    logic [15:0]         h_bits;
    logic [31:0]         h_comp;
    logic [31:0]         h_cu;
    logic [31:0]         pal_chk;
    logic                pal_mode_h;
    logic                depth_ok;
    logic [DIM_W-1:0]    w_small;
    logic [DIM_W-1:0]    h_small;
    logic [2*DIM_W-1:0]  wh_prod;
    logic [3:0]          eval1_code;
    logic [DIM_W+5:0]    wb;
    logic [DIM_W+6:0]    wb31;
    logic [DIM_W:0]      w31;

    logic                pal_mode;
    logic                d32;
    logic [ADDR_W-1:0]   total;
    logic [ADDR_W-1:0]   scan_addr;
    logic [7:0]          scan_idx;
    logic                scan_err;
    logic [DIM_W-1:0]    inv;
    logic [7:0]          pidx;
    logic [ADDR_W-1:0]   pb;
    logic [ADDR_W-1:0]   pix_addr;

    icod_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[PAY_AW-1:0]),
        .wdata (data_byte),
        .raddr (raddr_w[PAY_AW-1:0]),
        .rdata (rdata)
    );

    assign we = cmd.load && (cnt_reg < CNT_W'(PAYLOAD_BYTES));

    assign h_size   = hdr_reg[31:0];
    assign h_w      = hdr_reg[63:32];
    assign h_dh     = hdr_reg[95:64];
    assign h_planes = hdr_reg[111:96];
    assign h_bits   = hdr_reg[127:112];
    assign h_comp   = hdr_reg[159:128];
    assign h_cu     = hdr_reg[287:256];
    assign w_small  = h_w[DIM_W-1:0];
    assign h_small  = h_dh[DIM_W:1];
    assign wh_prod  = w_small * h_small;
    assign pal_mode_h = (h_bits <= 16'(DEPTH_8));
    assign pal_chk  = (h_cu != 32'd0) ? h_cu : (32'd1 << h_bits[3:0]);
    assign wb       = w_small * h_bits[5:0];
    assign wb31     = {1'b0, wb} + (DIM_W+7)'(31);
    assign w31      = {1'b0, w_small} + (DIM_W+1)'(31);

    always_comb
    begin
        depth_ok = h_bits inside {16'(DEPTH_1), 16'(DEPTH_4), 16'(DEPTH_8),
                                  16'(DEPTH_24), 16'(DEPTH_32)};
        if ((cnt_reg > CNT_W'(PNG_MIN)) && (hdr_reg[63:0] == PNG_SIG))
        begin
            eval1_code = ST_PNG;
        end
        else if (cnt_reg < CNT_W'(BMP_HDR_SIZE))
        begin
            eval1_code = ST_SHORT;
        end
        else if ((h_size != 32'(BMP_HDR_SIZE)) || (h_planes != 16'd1) || (h_comp != 32'd0))
        begin
            eval1_code = ST_HDR;
        end
        else if ((h_w == 32'd0) || (h_w > 32'(MAX_DIM)) || (h_dh == 32'd0) || h_dh[0]
                 || ({1'b0, h_dh[31:1]} > 32'(MAX_DIM))
                 || (32'(wh_prod) > 32'(MAX_PIXELS)))
        begin
            eval1_code = ST_DIMS;
        end
        else if (!depth_ok)
        begin
            eval1_code = ST_DEPTH;
        end
        else if (pal_mode_h && (pal_chk > 32'(PAL_MAX)))
        begin
            eval1_code = ST_PAL;
        end
        else
        begin
            eval1_code = ST_OK;
        end
    end

    assign pal_mode = (bits_reg <= DEPTH_8);
    assign d32      = (bits_reg == DEPTH_32);
    assign total    = abase_reg + ADDR_W'(as_reg) * ADDR_W'(h_reg);

    always_comb
    begin
        case (bits_reg)
            DEPTH_32: scan_addr = scan_row_reg + ADDR_W'({scan_x_reg, 2'b11});
            DEPTH_8:  scan_addr = scan_row_reg + ADDR_W'(scan_x_reg);
            DEPTH_4:  scan_addr = scan_row_reg + ADDR_W'(scan_x_reg >> 1);
            default:  scan_addr = scan_row_reg + ADDR_W'(scan_x_reg >> 3);
        endcase
        case (bits_reg)
            DEPTH_8:  pix_addr = xrow_reg + ADDR_W'(col_reg);
            DEPTH_4:  pix_addr = xrow_reg + ADDR_W'(col_reg >> 1);
            default:  pix_addr = xrow_reg + ADDR_W'(col_reg >> 3);
        endcase
    end

    assign scan_idx = pal_index(rdata, scan_x_reg[2:0], bits_reg);
    assign scan_err = pal_mode && ({1'b0, scan_idx} >= pal_reg);
    assign inv      = h_reg - DIM_W'(1) - row_reg;
    assign pidx     = pal_index(pix_reg, col_reg[2:0], bits_reg);

    always_comb
    begin
        if (pal_mode)
        begin
            pb = ADDR_W'(BMP_HDR_SIZE) + ADDR_W'({pidx, 2'b00});
        end
        else if (d32)
        begin
            pb = xrow_reg + ADDR_W'({col_reg, 2'b00});
        end
        else
        begin
            pb = xrow_reg + ADDR_W'({col_reg, 1'b0}) + ADDR_W'(col_reg);
        end
    end

    always_comb
    begin
        raddr_w  = '0;
        cap_next = CAP_NONE;
        case (cmd.op)
            S_HDR:
            begin
                raddr_w  = ADDR_W'(hidx_reg);
                cap_next = CAP_HDR;
            end
            S_SCAN_RD: raddr_w = scan_addr;
            S_F_MASK:
            begin
                raddr_w  = arow_reg + ADDR_W'(col_reg >> 3);
                cap_next = CAP_MASK;
            end
            S_F_PIX:
            begin
                raddr_w  = pix_addr;
                cap_next = CAP_PIX;
            end
            S_F_PB:
            begin
                raddr_w  = pb;
                cap_next = CAP_B;
            end
            S_F_PG:
            begin
                raddr_w  = pb + ADDR_W'(1);
                cap_next = CAP_G;
            end
            S_F_PR:
            begin
                raddr_w  = pb + ADDR_W'(2);
                cap_next = CAP_R;
            end
            S_F_PA:
            begin
                raddr_w  = pb + ADDR_W'(3);
                cap_next = (d32 && alpha_seen_reg) ? CAP_A : CAP_NONE;
            end
            default:
            begin
                raddr_w  = '0;
                cap_next = CAP_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            S_CHK_START:
            begin
                if (cnt_reg > CNT_W'(PAYLOAD_BYTES))
                begin
                    code_comb = ST_BIG;
                end
                else if (cnt_reg <= CNT_W'(PNG_MIN))
                begin
                    code_comb = ST_SHORT;
                end
                else
                begin
                    code_comb = ST_OK;
                end
            end
            S_EVAL1:    code_comb = eval1_code;
            S_EVAL3:    code_comb = (total > ADDR_W'(cnt_reg)) ? ST_TRUNC : ST_OK;
            S_SCAN_CHK: code_comb = scan_err ? ST_INDEX : ST_OK;
            default:    code_comb = ST_OK;
        endcase
    end

    assign sts.code_nz   = (code_comb != ST_OK);
    assign sts.hdr_last  = (hidx_reg == HIDX_W'(HDR_BYTES - 1));
    assign sts.pal_mode  = pal_mode;
    assign sts.scan_en   = pal_mode || d32;
    assign sts.scan_last = (scan_x_reg == w_reg - DIM_W'(1))
                           && (scan_y_reg == h_reg - DIM_W'(1));
    assign sts.fetch_ok  = ready_reg && (row_reg < h_reg) && (col_reg < w_reg);
    assign sts.out_busy  = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            bits_reg       <= '0;
            pal_reg        <= '0;
            alpha_seen_reg <= 1'b0;
            ready_reg      <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            hidx_reg       <= '0;
            cap_reg        <= CAP_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cap_reg <= cap_next;
            case (cmd.op)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        if (cnt_reg <= CNT_W'(PAYLOAD_BYTES))
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        ready_reg <= 1'b0;
                    end
                    if (cmd.miss)
                    begin
                        ready_reg <= 1'b0;
                    end
                end
                S_CHK_START: hidx_reg <= '0;
                S_HDR:       hidx_reg <= hidx_reg + HIDX_W'(1);
                S_EVAL1:
                begin
                    w_reg    <= w_small;
                    h_reg    <= h_small;
                    bits_reg <= h_bits[5:0];
                    pal_reg  <= pal_mode_h ? pal_chk[8:0] : 9'd0;
                end
                S_EVAL3:     alpha_seen_reg <= 1'b0;
                S_SCAN_CHK:
                begin
                    if (d32 && (rdata != 8'd0))
                    begin
                        alpha_seen_reg <= 1'b1;
                    end
                end
                S_CHK_RES:
                begin
                    cnt_reg   <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    ready_reg <= (code_reg == ST_OK);
                    if (code_reg != ST_OK)
                    begin
                        w_reg          <= '0;
                        h_reg          <= '0;
                        bits_reg       <= '0;
                        pal_reg        <= '0;
                        alpha_seen_reg <= 1'b0;
                    end
                end
                S_F_RES:
                begin
                    if (col_reg + DIM_W'(1) >= w_reg)
                    begin
                        col_reg <= '0;
                        if (row_reg + DIM_W'(1) >= h_reg)
                        begin
                            row_reg   <= '0;
                            ready_reg <= 1'b0;
                        end
                        else
                        begin
                            row_reg <= row_reg + DIM_W'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + DIM_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cap_reg)
            CAP_HDR:  hdr_reg  <= {rdata, hdr_reg[HDR_W-1:8]};
            CAP_MASK: mask_reg <= rdata[3'd7 - col_reg[2:0]];
            CAP_PIX:  pix_reg  <= rdata;
            CAP_B:    b_reg    <= rdata;
            CAP_G:    g_reg    <= rdata;
            CAP_R:    r_reg    <= rdata;
            CAP_A:    a_reg    <= rdata;
            default:
            begin
            end
        endcase
        case (cmd.op)
            S_IDLE:
            begin
                if (cmd.miss)
                begin
                    sel_reg <= RES_EMPTY;
                end
            end
            S_CHK_START: code_reg <= code_comb;
            S_EVAL1:
            begin
                code_reg <= code_comb;
                xs_reg   <= {wb31[DIM_W+6:5], 2'b00};
                as_reg   <= {w31[DIM_W:5], 2'b00};
                off_reg  <= OFF_W'(BMP_HDR_SIZE)
                            + OFF_W'({(pal_mode_h ? pal_chk[8:0] : 9'd0), 2'b00});
            end
            S_EVAL2:     abase_reg <= ADDR_W'(off_reg) + ADDR_W'(xs_reg) * ADDR_W'(h_reg);
            S_EVAL3:
            begin
                code_reg     <= code_comb;
                scan_x_reg   <= '0;
                scan_y_reg   <= '0;
                scan_row_reg <= ADDR_W'(off_reg);
            end
            S_SCAN_CHK:
            begin
                code_reg <= code_comb;
                if (scan_x_reg == w_reg - DIM_W'(1))
                begin
                    scan_x_reg   <= '0;
                    scan_y_reg   <= scan_y_reg + DIM_W'(1);
                    scan_row_reg <= scan_row_reg + ADDR_W'(xs_reg);
                end
                else
                begin
                    scan_x_reg <= scan_x_reg + DIM_W'(1);
                end
            end
            S_CHK_RES:   sel_reg <= RES_CHK;
            S_F_ADDR:
            begin
                xrow_reg <= ADDR_W'(off_reg) + ADDR_W'(inv) * ADDR_W'(xs_reg);
                arow_reg <= abase_reg + ADDR_W'(inv) * ADDR_W'(as_reg);
            end
            S_F_MASK:    a_reg <= 8'hFF;
            S_F_RES:
            begin
                sel_reg  <= RES_PIX;
                last_reg <= (col_reg + DIM_W'(1) >= w_reg) && (row_reg + DIM_W'(1) >= h_reg);
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            kind_reg    <= (sel_reg != RES_CHK);
            status_reg  <= (sel_reg == RES_CHK) ? code_reg
                           : ((sel_reg == RES_EMPTY) ? ST_EMPTY : ST_OK);
            width_reg   <= (sel_reg == RES_EMPTY) ? '0 : w_reg;
            height_reg  <= (sel_reg == RES_EMPTY) ? '0 : h_reg;
            red_reg     <= (sel_reg == RES_PIX) ? r_reg : 8'd0;
            green_reg   <= (sel_reg == RES_PIX) ? g_reg : 8'd0;
            blue_reg    <= (sel_reg == RES_PIX) ? b_reg : 8'd0;
            alpha_reg   <= (sel_reg == RES_PIX && !mask_reg) ? a_reg : 8'd0;
            lastpix_reg <= (sel_reg == RES_PIX) && last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign last_pixel   = lastpix_reg;

endmodule

// File: rtl/core/ico_bitmap_pixel_decoder_top.sv
// ============================================================================
// ico_bitmap_pixel_decoder_top
// icon payload loader, bitmap header checker and argb pixel reader
// ============================================================================
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid, in_stall  | func, data_byte, last_byte
//  out     | out_valid, out_stall| kind, status, image_width, image_height,
//          |                     | red, green, blue, alpha, last_pixel
//
//  a byte load stores the byte, up to the store depth; the final byte runs the check,
//  which scans 1/4/8/32-bit images with one store read per pixel
//  a pixel fetch reads the byte store in steps over its single read port
//  (mask, pixel byte via palette only, b, g, r, a)
//  reset clears all control state; the store needs no clearing
//  one result waits in the output register while the next request is taken
// ============================================================================
module ico_bitmap_pixel_decoder_top import icod_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             kind,
    output logic [3:0]       status,
    output logic [DIM_W-1:0] image_width,
    output logic [DIM_W-1:0] image_height,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_pixel
);

    cmd_t cmd;
    sts_t sts;

    icod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .last_byte (last_byte),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    icod_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .out_stall    (out_stall),
        .sts          (sts),
        .out_valid    (out_valid),
        .kind         (kind),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_pixel   (last_pixel)
    );

endmodule

// File: rtl/core/icod_chk.sv
// ============================================================================
// icod_chk
// port level checks of the icon bitmap pixel decoder
// ============================================================================
module icod_chk import icod_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             func,
    input logic [7:0]       data_byte,
    input logic             last_byte,
    input logic             out_valid,
    input logic             out_stall,
    input logic             kind,
    input logic [3:0]       status,
    input logic [DIM_W-1:0] image_width,
    input logic [DIM_W-1:0] image_height,
    input logic [7:0]       red,
    input logic [7:0]       green,
    input logic [7:0]       blue,
    input logic [7:0]       alpha,
    input logic             last_pixel
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(red))
        else $error("stalled result changed");

    // a fetch request always keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func |=> in_stall)
        else $error("fetch finished too early");

    // a failed check reports no image size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind && (status != ST_OK) |-> (image_width == '0) && (image_height == '0))
        else $error("size shown with failed check");

    // end of image only on a good pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> kind && (status == ST_OK))
        else $error("last pixel flag on a non-pixel result");

endmodule

bind ico_bitmap_pixel_decoder_top icod_chk u_icod_chk (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: icon bitmap pixel decoder testbench
// loads icon payloads byte by byte, runs the header check and reads pixels
// back; an in-bench predictor of the decoder works out every status and
// pixel, and each result is compared with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top import icod_pkg::*; ();

    typedef struct {
        logic       k;
        logic [3:0] st;
        logic [8:0] w;
        logic [8:0] h;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       lp;
    } dec_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       func = 1'b0;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [3:0] status;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [7:0] red, green, blue, alpha;
    logic       last_pixel;

    ico_bitmap_pixel_decoder_top u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .status(status), .image_width(image_width), .image_height(image_height),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .last_pixel(last_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted decoder state
    logic [7:0] store_img [0:PAYLOAD_BYTES-1];
    longint     p_cnt, p_w, p_h, p_bits, p_pal;
    bit         p_alpha_seen, p_ready;
    longint     p_col, p_row;

    dec_out_t   due_q[$];
    logic [7:0] pay[$];
    int         n_sent = 0;
    int         n_pixels = 0;
    int         n_status = 0;
    int         mismatches = 0;
    int         fails = 0;
    bit         send_idle = 1'b1;
    bit         recv_idle = 1'b1;
    bit         hold_req = 1'b0;
    int         hold_left = 0;

    function automatic longint rd8(longint a);
        return (a < PAYLOAD_BYTES) ? longint'(store_img[int'(a)]) : 0;
    endfunction

    function automatic longint rd16(longint a);
        return rd8(a) | (rd8(a + 1) << 8);
    endfunction

    function automatic longint rd32(longint a);
        return rd16(a) | (rd16(a + 2) << 16);
    endfunction

    function automatic longint xor_base();
        return 40 + p_pal * 4;
    endfunction

    function automatic longint xor_pitch();
        return ((p_w * p_bits + 31) / 32) * 4;
    endfunction

    function automatic longint and_pitch();
        return ((p_w + 31) / 32) * 4;
    endfunction

    function automatic longint colour_index(longint x, longint y);
        longint row;
        longint v;
        row = xor_base() + (p_h - 1 - y) * xor_pitch();
        if (p_bits == 8)
            return rd8(row + x);
        if (p_bits == 4)
        begin
            v = rd8(row + x / 2);
            return (x % 2 == 0) ? (v >> 4) : (v & 'h0F);
        end
        v = rd8(row + x / 8);
        return ((v & ('h80 >> (x % 8))) != 0) ? 1 : 0;
    endfunction

    function automatic logic [3:0] check_icon(longint n);
        logic [63:0] sig;
        longint w, dh, h, bits, cu, pal, total, row;
        pal = 0;
        if (n > PAYLOAD_BYTES)
            return ST_BIG;
        if (n > PNG_MIN)
        begin
            for (int i = 0; i < 8; i++)
                sig[8*i +: 8] = rd8(i);
            if (sig == PNG_SIG)
                return ST_PNG;
        end
        if (n < BMP_HDR_SIZE)
            return ST_SHORT;
        if (rd32(0) != 40 || rd16(12) != 1 || rd32(16) != 0)
            return ST_HDR;
        w = rd32(4);
        dh = rd32(8);
        if (w == 0 || w > MAX_DIM || dh == 0 || dh % 2 != 0)
            return ST_DIMS;
        h = dh / 2;
        if (h > MAX_DIM || w * h > MAX_PIXELS)
            return ST_DIMS;
        bits = rd16(14);
        if (bits != 1 && bits != 4 && bits != 8 && bits != 24 && bits != 32)
            return ST_DEPTH;
        if (bits <= 8)
        begin
            cu = rd32(32);
            pal = (cu != 0) ? cu : (longint'(1) << bits);
            if (pal > PAL_MAX)
                return ST_PAL;
        end
        p_w = w;
        p_h = h;
        p_bits = bits;
        p_pal = pal;
        total = xor_base() + (xor_pitch() + and_pitch()) * h;
        if (total > n)
            return ST_TRUNC;
        p_alpha_seen = 1'b0;
        for (longint y = 0; y < h; y++)
        begin
            row = xor_base() + (h - 1 - y) * xor_pitch();
            for (longint x = 0; x < w; x++)
            begin
                if (bits <= 8)
                begin
                    if (colour_index(x, y) >= pal)
                        return ST_INDEX;
                end
                else if (bits == 32 && rd8(row + x * 4 + 3) != 0)
                begin
                    p_alpha_seen = 1'b1;
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic void decode_step(logic f, logic [7:0] d, logic lb);
        dec_out_t   o;
        logic [3:0] st;
        longint     inv, xrow, arow, p;
        bit         masked;
        o = '{1'b0, 4'd0, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        if (!f)
        begin
            if (p_cnt < PAYLOAD_BYTES)
                store_img[int'(p_cnt)] = d;
            if (p_cnt <= PAYLOAD_BYTES)
                p_cnt++;
            p_ready = 1'b0;
            if (!lb)
                return;
            st = check_icon(p_cnt);
            p_cnt = 0;
            p_col = 0;
            p_row = 0;
            if (st == ST_OK)
            begin
                p_ready = 1'b1;
            end
            else
            begin
                p_w = 0;
                p_h = 0;
                p_bits = 0;
                p_pal = 0;
                p_alpha_seen = 1'b0;
            end
            o.st = st;
            o.w = p_w[8:0];
            o.h = p_h[8:0];
            due_q.push_back(o);
            return;
        end
        o.k = 1'b1;
        if (!p_ready || p_row >= p_h || p_col >= p_w)
        begin
            p_ready = 1'b0;
            o.st = ST_EMPTY;
            due_q.push_back(o);
            return;
        end
        inv = p_h - 1 - p_row;
        xrow = xor_base() + inv * xor_pitch();
        arow = xor_base() + xor_pitch() * p_h + inv * and_pitch();
        masked = (rd8(arow + p_col / 8) & ('h80 >> (p_col % 8))) != 0;
        o.a = 8'hFF;
        if (p_bits >= 24)
        begin
            p = xrow + p_col * (p_bits / 8);
            if (p_bits == 32 && p_alpha_seen)
                o.a = rd8(p + 3);
        end
        else
        begin
            p = 40 + colour_index(p_col, p_row) * 4;
        end
        o.b = rd8(p);
        o.g = rd8(p + 1);
        o.r = rd8(p + 2);
        if (masked)
            o.a = 8'd0;
        o.st = ST_OK;
        o.w = p_w[8:0];
        o.h = p_h[8:0];
        p_col++;
        if (p_col >= p_w)
        begin
            p_col = 0;
            p_row++;
            if (p_row >= p_h)
            begin
                p_row = 0;
                p_ready = 1'b0;
                o.lp = 1'b1;
            end
        end
        due_q.push_back(o);
    endfunction

    // result checking
    always @(posedge clk)
    begin
        dec_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_q.size() == 0)
            begin
                fails++;
                $display("unexpected result kind=%0d status=%0d", kind, status);
            end
            else
            begin
                e = due_q.pop_front();
                if (kind) n_pixels++; else n_status++;
                if (e.k !== kind || e.st !== status || e.w !== image_width
                    || e.h !== image_height || e.r !== red || e.g !== green
                    || e.b !== blue || e.a !== alpha || e.lp !== last_pixel)
                begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp k%0d s%0d %0dx%0d argb %h%h%h%h l%0d / got k%0d s%0d %0dx%0d argb %h%h%h%h l%0d",
                                 e.k, e.st, e.w, e.h, e.a, e.r, e.g, e.b, e.lp,
                                 kind, status, image_width, image_height,
                                 alpha, red, green, blue, last_pixel);
                end
            end
        end
    end

    // receiver stalls, with one long hold counted in cycles
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= recv_idle && ($urandom_range(99) < 38);
        end
    end

    task automatic send_req(logic f, logic [7:0] d, logic lb);
        while (send_idle && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_byte <= d;
        last_byte <= lb;
        do
            @(posedge clk);
        while (in_stall);
        decode_step(f, d, lb);
        n_sent++;
    endtask

    task automatic send_payload();
        foreach (pay[i])
            send_req(1'b0, pay[i], i == pay.size() - 1);
    endtask

    task automatic fetch_pixels(int n);
        repeat ((n > 0) ? n : 0)
            send_req(1'b1, $urandom, $urandom);
    endtask

    task automatic put_le(int off, longint v, int nb);
        for (int i = 0; i < nb; i++)
            pay[off + i] = v >> (8 * i);
    endtask

    // well-formed bitmap icon, optionally with one out-of-range palette index
    task automatic build_icon(int bits, int w, int h, int cu, bit alpha_on, bit bad_idx);
        int pal, xs, as, idx, bx, by;
        logic [7:0] rb[];
        pay.delete();
        repeat (40)
            pay.push_back($urandom);
        put_le(0, 40, 4);
        put_le(4, w, 4);
        put_le(8, 2 * h, 4);
        put_le(12, 1, 2);
        put_le(14, bits, 2);
        put_le(16, 0, 4);
        put_le(32, cu, 4);
        pal = (bits <= 8) ? ((cu != 0) ? cu : (1 << bits)) : 0;
        repeat (pal * 4)
            pay.push_back($urandom);
        xs = ((w * bits + 31) / 32) * 4;
        bx = $urandom_range(w - 1);
        by = $urandom_range(h - 1);
        for (int y = 0; y < h; y++)
        begin
            rb = new[xs];
            foreach (rb[i])
                rb[i] = $urandom;
            for (int x = 0; x < w; x++)
            begin
                if (bits <= 8)
                begin
                    idx = $urandom_range(pal - 1);
                    if (bad_idx && x == bx && y == by && pal < (1 << bits))
                        idx = $urandom_range((1 << bits) - 1, pal);
                    if (bits == 8)
                        rb[x] = idx;
                    else if (bits == 4 && x % 2 == 0)
                        rb[x / 2][7:4] = idx;
                    else if (bits == 4)
                        rb[x / 2][3:0] = idx;
                    else
                        rb[x / 8][7 - x % 8] = idx[0];
                end
                else if (bits == 32 && !alpha_on)
                begin
                    rb[x * 4 + 3] = 8'd0;
                end
            end
            foreach (rb[i])
                pay.push_back(rb[i]);
        end
        as = ((w + 31) / 32) * 4;
        idx = $urandom_range(3);
        repeat (h * as)
            pay.push_back((idx == 0) ? 8'd0 : (idx == 1) ? 8'hFF : 8'($urandom));
    endtask

    function automatic int pick_depth();
        int t;
        t = $urandom_range(4);
        return (t == 0) ? 1 : (t == 1) ? 4 : (t == 2) ? 8 : (t == 3) ? 24 : 32;
    endfunction

    task automatic random_icon(bit bad_idx);
        int bits, cu;
        bits = pick_depth();
        cu = 0;
        if (bits == 8 || ($urandom_range(1) && bits <= 4))
            cu = $urandom_range(1, (bits == 1) ? 2 : 16);
        build_icon(bits, $urandom_range(1, 8), $urandom_range(1, 3), cu,
                   $urandom_range(1), bad_idx);
    endtask

    task automatic test_empty_fetch();
        fetch_pixels(2);
    endtask

    task automatic test_rejects();
        pay.delete();
        repeat (39)
            pay.push_back($urandom);
        pay[0] = 8'h00;
        send_payload();
        pay.delete();
        for (int i = 0; i < 25; i++)
            pay.push_back((i < 8) ? PNG_SIG[8*i +: 8] : 8'($urandom));
        send_payload();
        void'(pay.pop_back());
        send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(0, 41, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(12, 2, 2); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(16, 1, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(4, 0, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(4, 257, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(8, 3, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(8, 0, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(8, 514, 4); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(14, 16, 2); send_payload();
        build_icon(8, 2, 1, 3, 0, 0); put_le(32, 257, 4); send_payload();
        build_icon(24, 3, 2, 0, 0, 0); void'(pay.pop_back()); send_payload();
        build_icon(4, 5, 2, 5, 0, 1); send_payload();
        build_icon(8, 5, 2, 9, 0, 1); send_payload();
        fetch_pixels(1);
    endtask

    task automatic test_oversize();
        for (int i = 0; i <= PAYLOAD_BYTES; i++)
            send_req(1'b0, $urandom, i == PAYLOAD_BYTES);
    endtask

    task automatic test_depths();
        build_icon(1, 9, 2, 0, 0, 0);   send_payload(); fetch_pixels(19);
        build_icon(4, 7, 3, 0, 0, 0);   send_payload(); fetch_pixels(22);
        build_icon(8, 3, 2, 0, 0, 0);   send_payload(); fetch_pixels(7);
        build_icon(24, 5, 2, 0, 0, 0);  send_payload(); fetch_pixels(11);
        build_icon(32, 4, 2, 0, 1, 0);  send_payload(); fetch_pixels(9);
        build_icon(32, 4, 2, 0, 0, 0);  send_payload(); fetch_pixels(9);
    endtask

    task automatic test_widest();
        build_icon(1, 256, 1, 1, 0, 0);
        send_payload();
        fetch_pixels(257);
    endtask

    task automatic test_no_idle();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        build_icon(24, 8, 3, 0, 0, 0);
        send_payload();
        fetch_pixels(25);
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        build_icon(32, 8, 3, 0, 1, 0);
        send_payload();
        hold_req = 1'b1;
        fetch_pixels(24);
    endtask

    task automatic test_random();
        int start, c;
        start = n_sent;
        while (n_sent - start < 950)
        begin
            c = $urandom_range(9);
            if (c == 0)
            begin
                pay.delete();
                repeat ($urandom_range(1, 60))
                    pay.push_back($urandom);
                send_payload();
            end
            else if (c == 1)
            begin
                random_icon(0);
                pay[$urandom_range(39)] = $urandom;
                send_payload();
                fetch_pixels($urandom_range(2));
            end
            else
            begin
                random_icon(c == 2);
                send_payload();
                fetch_pixels(p_w * p_h + (($urandom_range(3) == 0) ? -1 : $urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        store_img = '{default: 8'd0};
        p_cnt = 0; p_w = 0; p_h = 0; p_bits = 0; p_pal = 0;
        p_alpha_seen = 0; p_ready = 0; p_col = 0; p_row = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_fetch();
        test_rejects();
        test_depths();
        test_widest();
        test_no_idle();
        test_backpressure();
        test_oversize();
        test_random();
        in_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        $display("%0d requests sent, %0d status and %0d pixel results checked",
                 n_sent, n_status, n_pixels);
        $display("covered every status code, all bit depths, masks and stalls");
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/icod_pkg.sv
rtl/core/icod_ram.sv
rtl/core/icod_ctrl.sv
rtl/core/icod_dp.sv
rtl/core/ico_bitmap_pixel_decoder_top.sv
rtl/core/icod_chk.sv
dv/tb_top.sv
